// ----- rtl/vgac_pkg.sv -----
package vgac_pkg;

  localparam int MAX_BLOCK = 24;

  // Q2.21 fixed point
  localparam int ONE_Q21 = 1 << 21;
  localparam logic signed [31:0] TANH_LIM = 32'sd7340032;  // 3.5 in Q2.21
  localparam logic signed [31:0] ONE_S32 = 32'sd2097152;
  localparam logic [16:0] DRIVE_MAX = 17'd65536;
  localparam logic [16:0] DRIVE_HALF = 17'd32768;
  localparam logic [16:0] DRIVE_MIN = 17'd656;
  localparam logic [16:0] FUZZ_MIN = 17'd65;

  // divide by five: multiply by ceil(2^26 / 5), exact for operands below 2^26
  localparam logic signed [31:0] X5_RECIP = 32'sd13421773;
  localparam int X5_SHIFT = 26;

  // shared divider: 52-bit dividend, 29-bit divisor, one quotient bit a cycle
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 29;
  localparam int DIV_CW = $clog2(DIV_NW);
  localparam logic [DIV_DW-1:0] TANH_K27 = DIV_DW'(27 * ONE_Q21);

  localparam logic [1:0] REG_DRIVE = 2'd0;
  localparam logic [1:0] REG_ENGINE = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;

  localparam logic [4:0] ENG_FM_LO = 5'd2;
  localparam logic [4:0] ENG_FM_HI = 5'd4;

  typedef enum logic [1:0] {
    CMD_GATE,
    CMD_BLOCK,
    CMD_SAMPLE,
    CMD_UNKNOWN
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_FADE,
    MODE_MUTE,
    MODE_RAMP
  } gmode_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_GATE, OP_BLOCK, OP_SETUP, OP_CY,
    OP_TCHK, OP_TSQ, OP_TY2, OP_TNUM, OP_TDIV, OP_TFIN,
    OP_CDIV, OP_CFIN, OP_MDIV, OP_MFIN,
    OP_XLOAD, OP_X5DIV, OP_X5FIN, OP_XGMUL, OP_XG,
    OP_SMUL, OP_SAT, OP_HMUL, OP_HARD, OP_FMUL, OP_FUZZ, OP_MKMUL, OP_MK,
    OP_GMUL, OP_GDIV, OP_GFIN, OP_ADD, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PREP,
    S_TCHK, S_TSQ, S_TY2, S_TNUM, S_TDIV, S_TWAIT,
    S_CDIV, S_CWAIT, S_MDIV, S_MWAIT,
    S_XLOAD, S_X5DIV, S_X5WAIT, S_XGMUL, S_XG,
    S_SMUL, S_SAT, S_HMUL, S_HARD, S_FMUL, S_FUZZ, S_MKMUL, S_MK,
    S_GAIN, S_GDIV, S_GWAIT, S_ADD, S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   chan;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic sat_on;
    logic fuzz_on;
    logic y_clip;
    logic fm;
    logic gain_mul;
    logic div_busy;
  } dp_stat_t;

  // round(v / 2^sh), halves away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

// ----- rtl/voice_gate_anticlick_saturator.sv -----
// Output stage of one synth voice. Requests are taken one at a time, and a
// block start or a sample may wait for the output register. Each pass through
// the shared radix-2 divider (start, 52 quotient bits, collect) sets the rate:
// per channel, a fade or ramp gain adds one pass, FM scaling adds a multiply
// by the reciprocal of five, and a drive of 656 or above adds the saturator
// steps (and the hard-clip blend with fuzz) plus a tanh pass, cut short when
// the argument clips. Once per sample that drive also costs a tanh pass and
// two divider passes for compensation and makeup gain. One 32x32 multiplier
// is shared by every multiply step. The result register lets the next
// request in while a finished result waits to be taken.
module voice_gate_anticlick_saturator
  import vgac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic               gate_on,
  input  logic signed [15:0] voice_left,
  input  logic signed [15:0] voice_right,
  input  logic signed [23:0] mix_left,
  input  logic signed [23:0] mix_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic               trigger_high,
  output logic signed [23:0] sum_left,
  output logic signed [23:0] sum_right
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  vgac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  vgac_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .gate_on      (gate_on),
    .voice_left   (voice_left),
    .voice_right  (voice_right),
    .mix_left     (mix_left),
    .mix_right    (mix_right),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .result_kind  (result_kind),
    .trigger_high (trigger_high),
    .sum_left     (sum_left),
    .sum_right    (sum_right)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    dp_stat.div_busy |-> !in_ready)
    else $error("divider still busy while idle");

  a_trig_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> sum_left == '0 && sum_right == '0)
    else $error("trigger result carries sample data");

endmodule

// ----- rtl/vgac_div.sv -----
module vgac_div
  import vgac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic [DIV_NW-1:0] quot
);

  logic [DIV_DW:0]   rem;
  logic [DIV_NW-1:0] qr;
  logic [DIV_DW-1:0] dr;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  assign rem_sh = {rem[DIV_DW-1:0], qr[DIV_NW-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, dr};
  assign ge = !diff[DIV_DW+1];
  assign quot = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= DIV_CW'(DIV_NW - 1);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr <= num;
      dr <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DW:0] : rem_sh;
      qr <= {qr[DIV_NW-2:0], ge};
    end
  end

endmodule

// ----- rtl/vgac_datapath.sv -----
module vgac_datapath
  import vgac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic [1:0]         command,
  input  logic               gate_on,
  input  logic signed [15:0] voice_left,
  input  logic signed [15:0] voice_right,
  input  logic signed [23:0] mix_left,
  input  logic signed [23:0] mix_right,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               result_kind,
  output logic               trigger_high,
  output logic signed [23:0] sum_left,
  output logic signed [23:0] sum_right
);

  logic [16:0] drive;
  logic [4:0]  engine_select;
  logic [4:0]  block_size;

  logic        gate_level, note_on_pending, last_trigger_high, anticlick_faded;
  logic [2:0]  anticlick_count;
  gmode_t      block_gain_mode;
  logic [4:0]  sample_index;

  cmd_t               cmd_r;
  logic               gate_on_r;
  logic signed [15:0] vl, vr;
  logic signed [23:0] ml, mr;

  logic [16:0] d_r, fuzz_r;
  logic [19:0] gain_r;
  logic [4:0]  nsz, gfac;
  logic signed [31:0] y_r, x_r, xg_r, sat_r, hard_r, m_r;
  logic [26:0] y2_r;
  logic signed [22:0] t_r;
  logic [22:0] comp_r;
  logic [21:0] makeup_r;
  logic signed [63:0] prod;
  logic        div_neg;
  logic signed [23:0] res_l, res_r;
  logic        res_kind, res_trig;

  logic fm;
  assign fm = engine_select >= ENG_FM_LO && engine_select <= ENG_FM_HI;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
      engine_select <= '0;
      block_size <= 5'd24;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE:  drive <= cfg_data;
        REG_ENGINE: engine_select <= cfg_data[4:0];
        REG_BLOCK:  block_size <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // block-start decision
  logic   blk_trig, blk_pend, blk_faded;
  logic [2:0] blk_cnt;
  gmode_t blk_mode;

  always_comb begin
    blk_cnt = anticlick_count;
    blk_faded = anticlick_faded;
    blk_pend = note_on_pending;
    if (note_on_pending && last_trigger_high) begin
      blk_trig = 1'b0;
      if (fm && anticlick_count == 3'd0) begin
        blk_cnt = 3'd7;
        blk_faded = 1'b0;
      end
    end else if (note_on_pending) begin
      blk_trig = 1'b1;
      blk_pend = 1'b0;
      if (fm && anticlick_count == 3'd0) begin
        blk_cnt = 3'd6;
        blk_faded = 1'b0;
      end
    end else begin
      blk_trig = gate_level;
    end
    blk_mode = MODE_NONE;
    if (blk_cnt != 3'd0) begin
      if (!blk_faded) begin
        blk_mode = MODE_FADE;
        blk_faded = 1'b1;
      end else if (blk_cnt > 3'd1) begin
        blk_mode = MODE_MUTE;
      end else begin
        blk_mode = MODE_RAMP;
      end
      blk_cnt = blk_cnt - 3'd1;
    end
  end

  // per-sample settings
  logic [16:0] d_c;
  logic [19:0] gain_c;
  logic [16:0] fuzz_c;
  logic [4:0]  n_c, gfac_c;
  logic [5:0]  k_c;

  always_comb begin
    d_c = drive > DRIVE_MAX ? DRIVE_MAX : drive;
    if (d_c <= DRIVE_HALF) begin
      gain_c = 20'(32'd65536 + 32'd6 * 32'(d_c));
      fuzz_c = '0;
    end else begin
      gain_c = 20'(32'd262144 + 32'd10 * 32'(d_c - DRIVE_HALF));
      fuzz_c = 17'(32'd2 * 32'(d_c - DRIVE_HALF));
    end
    if (block_size == 5'd0) n_c = 5'd1;
    else if (32'(block_size) > MAX_BLOCK) n_c = 5'(MAX_BLOCK);
    else n_c = block_size;
    k_c = 6'(sample_index) + 6'd1;
    unique case (block_gain_mode)
      MODE_FADE: gfac_c = (k_c >= 6'(n_c)) ? 5'd0 : 5'(6'(n_c) - k_c);
      MODE_RAMP: gfac_c = (k_c >= 6'(n_c)) ? n_c : 5'(k_c);
      default:   gfac_c = 5'd0;
    endcase
  end

  // shared multiplier and divider operand selection
  logic signed [31:0] ma, mb, hard_c;
  logic signed [63:0] mprod;
  logic               mul_en;
  logic               div_start, div_neg_in, div_busy;
  logic [DIV_NW-1:0]  div_num, div_quot;
  logic [DIV_DW-1:0]  div_den, tden;
  logic [63:0]        pabs;
  logic [31:0]        xabs;
  logic [17:0]        mk_den;
  logic signed [52:0] qs;
  logic signed [31:0] x5q;
  logic signed [15:0] vsel;
  logic signed [23:0] msel;

  assign pabs = prod[63] ? 64'(-prod) : 64'(prod);
  assign xabs = x_r[31] ? 32'(-x_r) : 32'(x_r);
  assign tden = TANH_K27 + DIV_DW'(y2_r) * DIV_DW'(9);
  assign mk_den = 18'(d_r) + 18'd65536;
  assign hard_c = xg_r > ONE_S32 ? ONE_S32 : (xg_r < -ONE_S32 ? -ONE_S32 : xg_r);
  assign qs = div_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign x5q = 32'(prod >>> X5_SHIFT);
  assign vsel = cmd.chan ? vr : vl;
  assign msel = cmd.chan ? mr : ml;
  assign mprod = 64'(ma) * 64'(mb);

  always_comb begin
    ma = '0;
    mb = '0;
    mul_en = 1'b0;
    div_start = 1'b0;
    div_neg_in = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (cmd.op)
      OP_TSQ: begin
        ma = y_r; mb = y_r; mul_en = 1'b1;
      end
      OP_TNUM: begin
        ma = y_r; mb = $signed(32'(TANH_K27) + 32'(y2_r)); mul_en = 1'b1;
      end
      OP_XGMUL: begin
        ma = x_r; mb = $signed(32'(gain_r)); mul_en = 1'b1;
      end
      OP_SMUL: begin
        ma = 32'(t_r); mb = $signed(32'(comp_r)); mul_en = 1'b1;
      end
      OP_HMUL: begin
        ma = hard_c; mb = $signed(32'(comp_r)); mul_en = 1'b1;
      end
      OP_FMUL: begin
        ma = $signed(32'(fuzz_r)); mb = hard_r - sat_r; mul_en = 1'b1;
      end
      OP_MKMUL: begin
        ma = m_r; mb = $signed(32'(makeup_r)); mul_en = 1'b1;
      end
      OP_GMUL: begin
        ma = x_r; mb = $signed(32'(gfac)); mul_en = 1'b1;
      end
      OP_X5DIV: begin
        // magnitude plus half the divisor, rounded away from zero
        ma = $signed(xabs + 32'd2); mb = X5_RECIP; mul_en = 1'b1;
      end
      OP_TDIV: begin
        div_start = 1'b1;
        div_neg_in = prod[63];
        div_den = tden;
        div_num = DIV_NW'(pabs) + DIV_NW'(tden >> 1);
      end
      OP_CDIV: begin
        div_start = 1'b1;
        div_den = DIV_DW'(t_r[21:0]);
        div_num = (DIV_NW'(1) << 42) + (DIV_NW'(t_r[21:0]) >> 1);
      end
      OP_MDIV: begin
        div_start = 1'b1;
        div_den = DIV_DW'(mk_den);
        div_num = (DIV_NW'(1) << 37) + DIV_NW'(mk_den >> 1);
      end
      OP_GDIV: begin
        div_start = 1'b1;
        div_neg_in = prod[63];
        div_den = DIV_DW'(nsz);
        div_num = DIV_NW'(pabs) + DIV_NW'(nsz >> 1);
      end
      default: ;
    endcase
  end

  vgac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mprod;
    if (div_start) div_neg <= div_neg_in;
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_level <= 1'b0;
      note_on_pending <= 1'b0;
      last_trigger_high <= 1'b0;
      anticlick_count <= '0;
      anticlick_faded <= 1'b0;
      block_gain_mode <= MODE_NONE;
      sample_index <= '0;
    end else begin
      unique case (cmd.op)
        OP_GATE: begin
          if (gate_on_r) note_on_pending <= 1'b1;
          gate_level <= gate_on_r;
        end
        OP_BLOCK: begin
          note_on_pending <= blk_pend;
          last_trigger_high <= blk_trig;
          anticlick_count <= blk_cnt;
          anticlick_faded <= blk_faded;
          block_gain_mode <= blk_mode;
          sample_index <= '0;
        end
        OP_ADD: begin
          if (cmd.chan && sample_index != 5'd31) sample_index <= sample_index + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        cmd_r <= cmd_t'(command);
        gate_on_r <= gate_on;
        vl <= voice_left;
        vr <= voice_right;
        ml <= mix_left;
        mr <= mix_right;
      end
      OP_BLOCK: begin
        res_kind <= 1'b0;
        res_trig <= blk_trig;
        res_l <= '0;
        res_r <= '0;
      end
      OP_SETUP: begin
        d_r <= d_c;
        gain_r <= gain_c;
        fuzz_r <= fuzz_c;
        nsz <= n_c;
        gfac <= gfac_c;
      end
      OP_CY:    y_r <= $signed(32'(gain_r) << 5);
      OP_TCHK: begin
        if (y_r > TANH_LIM) t_r <= 23'sd2097152;
        else if (y_r < -TANH_LIM) t_r <= -23'sd2097152;
      end
      OP_TY2:   y2_r <= 27'(rshr(prod, 21));
      OP_TFIN:  t_r <= 23'(qs);
      OP_CFIN:  comp_r <= 23'(qs);
      OP_MFIN:  makeup_r <= 22'(qs);
      OP_XLOAD: x_r <= {{10{vsel[15]}}, vsel, 6'b0};
      OP_X5FIN: x_r <= x_r[31] ? -x5q : x5q;
      OP_XG: begin
        xg_r <= 32'(rshr(prod, 16));
        y_r <= 32'(rshr(prod, 16));
      end
      OP_SAT: begin
        sat_r <= 32'(rshr(prod, 21));
        m_r <= 32'(rshr(prod, 21));
      end
      OP_HARD:  hard_r <= 32'(rshr(prod, 21));
      OP_FUZZ:  m_r <= sat_r + 32'(rshr(prod, 16));
      OP_MK:    x_r <= 32'(rshr(prod, 21));
      OP_GFIN:  x_r <= 32'(qs);
      OP_ADD: begin
        if (cmd.chan) begin
          res_r <= sat24(64'(msel) + ((block_gain_mode == MODE_MUTE) ? 64'sd0 : 64'(x_r)));
          res_kind <= 1'b1;
          res_trig <= 1'b0;
        end else begin
          res_l <= sat24(64'(msel) + ((block_gain_mode == MODE_MUTE) ? 64'sd0 : 64'(x_r)));
        end
      end
      OP_OUT: begin
        result_kind <= res_kind;
        trigger_high <= res_trig;
        sum_left <= res_l;
        sum_right <= res_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.cmd = cmd_r;
    stat.sat_on = d_r >= DRIVE_MIN;
    stat.fuzz_on = fuzz_r > FUZZ_MIN;
    stat.y_clip = y_r > TANH_LIM || y_r < -TANH_LIM;
    stat.fm = fm;
    stat.gain_mul = block_gain_mode == MODE_FADE || block_gain_mode == MODE_RAMP;
    stat.div_busy = div_busy;
  end

endmodule

// ----- rtl/vgac_ctrl.sv -----
module vgac_ctrl
  import vgac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic chan, chan_next;
  logic ret_comp, ret_comp_next;
  logic out_valid_next;
  ctrl_state_t tanh_ret;

  assign tanh_ret = ret_comp ? S_CDIV : S_SMUL;
  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan <= 1'b0;
      ret_comp <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chan <= chan_next;
      ret_comp <= ret_comp_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    chan_next = chan;
    ret_comp_next = ret_comp;
    out_valid_next = out_valid && !out_ready;
    cmd.op = OP_NONE;
    cmd.chan = chan;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        chan_next = 1'b0;
        unique case (stat.cmd)
          CMD_GATE: begin
            cmd.op = OP_GATE;
            state_next = S_IDLE;
          end
          CMD_BLOCK: begin
            cmd.op = OP_BLOCK;
            state_next = S_FINISH;
          end
          CMD_SAMPLE: begin
            cmd.op = OP_SETUP;
            state_next = S_PREP;
          end
          CMD_UNKNOWN: state_next = S_IDLE;
        endcase
      end
      S_PREP: begin
        if (stat.sat_on) begin
          cmd.op = OP_CY;
          ret_comp_next = 1'b1;
          state_next = S_TCHK;
        end else begin
          state_next = S_XLOAD;
        end
      end
      // tanh approximation, shared by the compensation and the signal path
      S_TCHK: begin
        cmd.op = OP_TCHK;
        state_next = stat.y_clip ? tanh_ret : S_TSQ;
      end
      S_TSQ: begin
        cmd.op = OP_TSQ;
        state_next = S_TY2;
      end
      S_TY2: begin
        cmd.op = OP_TY2;
        state_next = S_TNUM;
      end
      S_TNUM: begin
        cmd.op = OP_TNUM;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        cmd.op = OP_TDIV;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_TFIN;
          state_next = tanh_ret;
        end
      end
      S_CDIV: begin
        cmd.op = OP_CDIV;
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_CFIN;
          state_next = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd.op = OP_MDIV;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_MFIN;
          state_next = S_XLOAD;
        end
      end
      S_XLOAD: begin
        cmd.op = OP_XLOAD;
        if (stat.fm) state_next = S_X5DIV;
        else state_next = stat.sat_on ? S_XGMUL : S_GAIN;
      end
      S_X5DIV: begin
        cmd.op = OP_X5DIV;
        state_next = S_X5WAIT;
      end
      S_X5WAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_X5FIN;
          state_next = stat.sat_on ? S_XGMUL : S_GAIN;
        end
      end
      S_XGMUL: begin
        cmd.op = OP_XGMUL;
        state_next = S_XG;
      end
      S_XG: begin
        cmd.op = OP_XG;
        ret_comp_next = 1'b0;
        state_next = S_TCHK;
      end
      S_SMUL: begin
        cmd.op = OP_SMUL;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.op = OP_SAT;
        state_next = stat.fuzz_on ? S_HMUL : S_MKMUL;
      end
      S_HMUL: begin
        cmd.op = OP_HMUL;
        state_next = S_HARD;
      end
      S_HARD: begin
        cmd.op = OP_HARD;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.op = OP_FMUL;
        state_next = S_FUZZ;
      end
      S_FUZZ: begin
        cmd.op = OP_FUZZ;
        state_next = S_MKMUL;
      end
      S_MKMUL: begin
        cmd.op = OP_MKMUL;
        state_next = S_MK;
      end
      S_MK: begin
        cmd.op = OP_MK;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        if (stat.gain_mul) begin
          cmd.op = OP_GMUL;
          state_next = S_GDIV;
        end else begin
          state_next = S_ADD;
        end
      end
      S_GDIV: begin
        cmd.op = OP_GDIV;
        state_next = S_GWAIT;
      end
      S_GWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_GFIN;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (!chan) begin
          chan_next = 1'b1;
          state_next = S_XLOAD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.op = OP_OUT;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- bench/voice_gate_anticlick_saturator_checker.sv -----
`timescale 1ns / 100ps
module voice_gate_anticlick_saturator_checker
  import vgac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         command,
  input  logic               gate_on,
  input  logic signed [15:0] voice_left,
  input  logic signed [15:0] voice_right,
  input  logic signed [23:0] mix_left,
  input  logic signed [23:0] mix_right,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               result_kind,
  input  logic               trigger_high,
  input  logic signed [23:0] sum_left,
  input  logic signed [23:0] sum_right,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic               kind;
    logic               trig;
    logic signed [23:0] left;
    logic signed [23:0] right;
  } mix_result_t;

  mix_result_t expected_mix[$];

  logic [16:0] m_drive;
  logic [4:0]  m_engine;
  logic [4:0]  m_block;
  logic        m_gate, m_pending, m_last_trig, m_faded;
  logic [2:0]  m_count;
  gmode_t      m_mode;
  logic [4:0]  m_index;

  assign pending_count = expected_mix.size();

  function automatic longint shr_round(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint pade_tanh(longint y);
    longint one, y2;
    one = longint'(1) << 21;
    if (y > 7 * one / 2) return one;
    if (y < -7 * one / 2) return -one;
    y2 = shr_round(y * y, 21);
    return div_near(y * (27 * one + y2), 27 * one + 9 * y2);
  endfunction

  function automatic longint shape(longint x, longint d);
    longint one, gain, fuzz, makeup, comp, xg, sat, hard, blend;
    one = longint'(1) << 21;
    if (d <= 32768) begin
      gain = 65536 + 6 * d;
      fuzz = 0;
    end else begin
      gain = 262144 + 10 * (d - 32768);
      fuzz = 2 * (d - 32768);
    end
    makeup = div_near(one * 65536, 65536 + d);
    comp = div_near(one * one, pade_tanh(gain * 32));
    xg = shr_round(x * gain, 16);
    sat = shr_round(pade_tanh(xg) * comp, 21);
    if (fuzz <= 65) return shr_round(sat * makeup, 21);
    hard = xg > one ? one : (xg < -one ? -one : xg);
    hard = shr_round(hard * comp, 21);
    blend = sat + shr_round(fuzz * (hard - sat), 16);
    return shr_round(blend * makeup, 21);
  endfunction

  function automatic longint voice_path(longint v, bit fm, longint n, longint k);
    longint x, d;
    x = fm ? div_near(v * 64, 5) : v * 64;
    d = m_drive > 17'd65536 ? 65536 : longint'(m_drive);
    if (d >= 656) x = shape(x, d);
    case (m_mode)
      MODE_FADE: x = div_near(x * (k >= n ? 0 : n - k), n);
      MODE_MUTE: x = 0;
      MODE_RAMP: x = div_near(x * (k >= n ? n : k), n);
      default: ;
    endcase
    return x;
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  task automatic predict_request();
    mix_result_t r;
    bit fm;
    longint n, k;
    fm = m_engine >= ENG_FM_LO && m_engine <= ENG_FM_HI;
    r = '0;
    case (cmd_t'(command))
      CMD_GATE: begin
        if (gate_on) m_pending = 1'b1;
        m_gate = gate_on;
      end
      CMD_BLOCK: begin
        if (m_pending && m_last_trig) begin
          r.trig = 1'b0;
          if (fm && m_count == 0) begin m_count = 7; m_faded = 0; end
        end else if (m_pending) begin
          r.trig = 1'b1;
          m_pending = 1'b0;
          if (fm && m_count == 0) begin m_count = 6; m_faded = 0; end
        end else begin
          r.trig = m_gate;
        end
        m_last_trig = r.trig;
        m_mode = MODE_NONE;
        if (m_count > 0) begin
          if (!m_faded) begin
            m_mode = MODE_FADE;
            m_faded = 1'b1;
          end else if (m_count > 1) m_mode = MODE_MUTE;
          else m_mode = MODE_RAMP;
          m_count--;
        end
        m_index = 0;
        expected_mix.push_back(r);
      end
      CMD_SAMPLE: begin
        n = m_block < 1 ? 1 : longint'(m_block);
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        k = longint'(m_index) + 1;
        r.kind = 1'b1;
        r.left = clip24(longint'(mix_left) + voice_path(voice_left, fm, n, k));
        r.right = clip24(longint'(mix_right) + voice_path(voice_right, fm, n, k));
        if (m_index < 5'd31) m_index++;
        expected_mix.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    mix_result_t e;
    if (rst) begin
      m_drive <= 0; m_engine <= 0; m_block <= 5'd24;
      m_gate = 0; m_pending = 0; m_last_trig = 0; m_faded = 0;
      m_count = 0; m_mode = MODE_NONE; m_index = 0;
      expected_mix.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DRIVE:  m_drive <= cfg_data;
          REG_ENGINE: m_engine <= cfg_data[4:0];
          REG_BLOCK:  m_block <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_request();
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          $error("unexpected result kind=%0d", result_kind);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_mix.pop_front();
          if (result_kind !== e.kind || trigger_high !== e.trig ||
              sum_left !== e.left || sum_right !== e.right) begin
            if (result_kind !== e.kind)
              $error("result_kind expected %0d got %0d", e.kind, result_kind);
            if (trigger_high !== e.trig)
              $error("trigger_high expected %0d got %0d", e.trig, trigger_high);
            if (sum_left !== e.left)
              $error("sum_left expected %0d got %0d", e.left, sum_left);
            if (sum_right !== e.right)
              $error("sum_right expected %0d got %0d", e.right, sum_right);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/voice_gate_anticlick_saturator_tb.sv -----
`timescale 1ns / 100ps
module voice_gate_anticlick_saturator_tb;
  import vgac_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = REG_DRIVE;
  logic [16:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         command = CMD_GATE;
  logic               gate_on = 0;
  logic signed [15:0] voice_left = 0;
  logic signed [15:0] voice_right = 0;
  logic signed [23:0] mix_left = 0;
  logic signed [23:0] mix_right = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               result_kind;
  logic               trigger_high;
  logic signed [23:0] sum_left;
  logic signed [23:0] sum_right;
  int                 fail_count;
  int                 pending_count;
  int                 ready_wait = 0;
  bit                 stim_done = 0;
  bit                 no_stall = 0;

  always #5 clk = ~clk;

  voice_gate_anticlick_saturator i_dut (.*);
  voice_gate_anticlick_saturator_checker i_check (.*);

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop the request, wait until every expected result has come, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // valid stays high into the next request when there is no gap
  task automatic send(logic [1:0] cmd, logic g, logic signed [15:0] vl,
                      logic signed [15:0] vr, logic signed [23:0] ml,
                      logic signed [23:0] mr);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    gate_on <= g;
    voice_left <= vl;
    voice_right <= vr;
    mix_left <= ml;
    mix_right <= mr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_sample();
    logic signed [23:0] ml, mr;
    ml = 24'($urandom);
    mr = 24'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      ml = $signed(ml) >>> $urandom_range(0, 12);
      mr = $signed(mr) >>> $urandom_range(0, 12);
    end
    send(CMD_SAMPLE, 1'($urandom), 16'($urandom), 16'($urandom), ml, mr);
  endtask

  // hold ready low for a drawn number of cycles after each result, unless no_stall
  always @(posedge clk) begin
    if (no_stall) out_ready <= 1'b1;
    else if (out_ready) begin
      if (out_valid) begin
        ready_wait = $urandom_range(0, 19);
        if (ready_wait != 0) out_ready <= 1'b0;
      end
    end else if (ready_wait > 1) ready_wait--;
    else out_ready <= 1'b1;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: trigger sequencing and extremes
    send(CMD_BLOCK, 0, 0, 0, 0, 0);
    send(CMD_SAMPLE, 0, 16'sh7FFF, -16'sh8000, 24'sh7FFFFF, 24'sh800000);
    send(CMD_SAMPLE, 0, -16'sh8000, 16'sh7FFF, 24'sh7FFFFF, 24'sh800000);
    send(CMD_GATE, 1, 0, 0, 0, 0);
    send(CMD_UNKNOWN, 1, 16'sh1234, 0, 0, 0);
    send(CMD_BLOCK, 0, 0, 0, 0, 0);
    send(CMD_GATE, 1, 0, 0, 0, 0);
    send(CMD_BLOCK, 0, 0, 0, 0, 0);
    send(CMD_BLOCK, 0, 0, 0, 0, 0);
    send(CMD_GATE, 0, 0, 0, 0, 0);
    send(CMD_BLOCK, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_DRIVE, 17'd65536);
    write_reg(REG_ENGINE, 17'd3);
    write_reg(REG_BLOCK, 17'd2);
    send(CMD_GATE, 1, 0, 0, 0, 0);
    for (int b = 0; b < 8; b++) begin
      send(CMD_BLOCK, 0, 0, 0, 0, 0);
      repeat (3) send(CMD_SAMPLE, 0, 16'sh7FFF, -16'sh8000, 0, 0);
    end
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_DRIVE, 17'd655); write_reg(REG_BLOCK, 17'd0); end
        1: begin write_reg(REG_DRIVE, 17'd656); write_reg(REG_ENGINE, 17'd2); end
        2: begin write_reg(REG_DRIVE, 17'h1FFFF); write_reg(REG_BLOCK, 17'd31); end
        3: begin write_reg(REG_DRIVE, 17'd32768); write_reg(REG_ENGINE, 17'd4); end
        4: begin write_reg(REG_DRIVE, 0); write_reg(REG_ENGINE, 17'd31); end
        5: begin write_reg(REG_DRIVE, 17'($urandom_range(0, 65536)));
                 write_reg(REG_ENGINE, 17'd4); write_reg(REG_BLOCK, 17'd1); end
        6: begin write_reg(REG_DRIVE, 17'd40000); write_reg(REG_BLOCK, 17'd24);
                 no_stall = 1; end
        default: begin write_reg(REG_DRIVE, 17'd20000); write_reg(REG_ENGINE, 17'd0);
                 write_reg(REG_BLOCK, 17'd4); no_stall = 0; end
      endcase
      for (int it = 0; it < 50; it++) begin
        case ($urandom_range(0, 19))
          0, 1: send(CMD_GATE, 1'($urandom), 16'($urandom), 16'($urandom),
                     24'($urandom), 24'($urandom));
          2, 3, 4: send(CMD_BLOCK, 1'($urandom), 16'($urandom), 16'($urandom),
                        24'($urandom), 24'($urandom));
          5: send(CMD_UNKNOWN, 1'($urandom), 16'($urandom), 16'($urandom),
                  24'($urandom), 24'($urandom));
          default: send_sample();
        endcase
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("voice_gate_anticlick_saturator: match");
    else $display("voice_gate_anticlick_saturator: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("voice_gate_anticlick_saturator: mismatch");
    $finish;
  end

endmodule
